// ----- rtl/mna_pkg.sv -----
// Shared constants and codes for the MIDI note arpeggiator.
`timescale 1ns / 1ps
package mna_pkg;

  localparam int NoteW = 7;
  localparam int PeriodW = 11;

  localparam logic [1:0] MODE_MIDI = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_STOP = 2'd2;

  localparam logic [3:0] STAT_NOTE_ON = 4'h9;
  localparam logic [3:0] STAT_NOTE_OFF = 4'h8;

  localparam logic [2:0] PAT_UP = 3'd0;
  localparam logic [2:0] PAT_DOWN = 3'd1;
  localparam logic [2:0] PAT_REP2 = 3'd2;
  localparam logic [2:0] PAT_UPDOWN = 3'd3;
  localparam logic [2:0] PAT_DOWNUP = 3'd4;
  localparam logic [2:0] PAT_REP3 = 3'd5;

  localparam logic [0:0] REG_PATTERN = 1'b0;
  localparam logic [0:0] REG_PERIOD = 1'b1;

  localparam logic [NoteW-1:0] ON_VELOCITY = 7'd100;
  localparam logic [PeriodW-1:0] ELAPSED_MAX = 11'd2047;
  localparam logic [PeriodW-1:0] PERIOD_RESET = 11'd500;

  localparam logic KIND_ON = 1'b0;
  localparam logic KIND_OFF = 1'b1;

endpackage

// ----- rtl/midi_note_arpeggiator_unit.sv -----
// Top level of the MIDI note arpeggiator.
// Input channel (in_valid / in_stall): mode 0 carries a MIDI event, mode 1 a
// one millisecond tick, mode 2 a stop command. Results leave on the output
// channel (out_valid / out_stall) as note-on or note-off messages, with
// last_of_run marking the final transfer caused by one input.
// Held notes live in a chain of MAX_NOTES cells that shift toward cell 0.
// A note-on, a tick without a beat and any ignored item cause no stall.
// A note-off walks the chain once in the remove state, one cell per cycle,
// then the emit state loads its note-off into the output register; in_stall
// stays high meanwhile. A beat loads its note-on from the emit state, which
// stalls the input. A stop presents one note-off per cycle while the output
// is not stalled, straight from the chain head, stalling until all are sent.
// An item may be accepted while a finished result waits in the output register.
// When out_stall is high with out_valid set, the output register holds and the work that needs
// it waits, adding those cycles to the stall. The configuration port is
// always ready; write it only while idle.
// Reset (rst, synchronous) empties the list, clears the pattern state and
// the tick counter, and restores pattern 0 and a 500 ms beat.
`timescale 1ns / 1ps
module midi_note_arpeggiator_unit
  import mna_pkg::*;
#(
  parameter int MAX_NOTES = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       mode,
  input  logic [7:0]       status_byte,
  input  logic [NoteW-1:0] note_number,
  input  logic [NoteW-1:0] velocity,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_kind,
  output logic [NoteW-1:0] out_note,
  output logic [NoteW-1:0] out_velocity,
  output logic             last_of_run,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [0:0]       cfg_index,
  input  logic [10:0]      cfg_data
);

  localparam int IW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int CW = $clog2(MAX_NOTES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_REMOVE = 2'd1;
  localparam logic [1:0] ST_STOP = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]         state;
  logic [2:0]         pattern;
  logic [PeriodW-1:0] period;
  logic [CW-1:0]      count;
  logic [IW-1:0]      idx;
  logic [1:0]         rep;
  logic               up;
  logic [PeriodW-1:0] elapsed;
  logic [CW-1:0]      len;
  logic [IW-1:0]      pos;
  logic [NoteW-1:0]   rm_note;
  logic               pend_kind;

  logic [NoteW-1:0]   cells [MAX_NOTES];
  logic [MAX_NOTES-1:0] cell_load;
  logic [NoteW-1:0]   cell_din;
  logic               shift;

  logic               accept;
  logic               slot_free;
  logic               out_load;
  logic [3:0]         stat;
  logic               is_on;
  logic               is_off;
  logic [PeriodW-1:0] elapsed_inc;
  logic               beat;
  logic [IW-1:0]      step_idx;
  logic [1:0]         step_rep;
  logic               step_up;
  logic [NoteW-1:0]   head;
  logic               keep;
  logic [CW-1:0]      len_next;
  logic               walk_last;

  assign cfg_ready = 1'b1;
  assign in_stall = (state != ST_IDLE);
  assign accept = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign out_load = slot_free && (state == ST_STOP || state == ST_EMIT);
  assign stat = status_byte[7:4];
  assign is_on = (stat == STAT_NOTE_ON) && (velocity != '0);
  assign is_off = (stat == STAT_NOTE_OFF) || (stat == STAT_NOTE_ON);
  assign elapsed_inc = (elapsed < ELAPSED_MAX) ? elapsed + PeriodW'(1) : ELAPSED_MAX;
  assign beat = (elapsed_inc >= period);
  assign head = cells[0];
  assign keep = (head != rm_note);
  assign len_next = keep ? len : len - CW'(1);
  assign walk_last = (CW'(pos) == count - CW'(1));

  mna_step #(
    .IW(IW),
    .CW(CW)
  ) u_step (
    .pattern (pattern),
    .count   (count),
    .idx     (idx),
    .rep     (rep),
    .up      (up),
    .idx_next(step_idx),
    .rep_next(step_rep),
    .up_next (step_up)
  );

  // chain control
  always_comb begin
    shift = 1'b0;
    cell_din = note_number;
    cell_load = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept && mode == MODE_MIDI && is_on && count < CW'(MAX_NOTES)) begin
          for (int i = 0; i < MAX_NOTES; i++) begin
            cell_load[i] = (CW'(i) == count);
          end
        end
      end
      ST_REMOVE: begin
        shift = 1'b1;
        cell_din = head;
        for (int i = 0; i < MAX_NOTES; i++) begin
          cell_load[i] = keep && (CW'(i) == len - CW'(1));
        end
      end
      ST_STOP: shift = slot_free;
      default: shift = 1'b0;
    endcase
  end

  for (genvar g = 0; g < MAX_NOTES; g++) begin : g_cell
    logic [NoteW-1:0] right;
    if (g == MAX_NOTES - 1) begin : g_end
      assign right = cells[g];
    end else begin : g_mid
      assign right = cells[g+1];
    end
    mna_cell u_cell (
      .clk       (clk),
      .load      (cell_load[g]),
      .shift     (shift),
      .load_note (cell_din),
      .right_note(right),
      .note      (cells[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern <= PAT_UP;
      period <= PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PATTERN: pattern <= cfg_data[2:0];
        REG_PERIOD: period <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      idx <= '0;
      rep <= '0;
      up <= 1'b1;
      elapsed <= '0;
      len <= '0;
      pos <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (mode)
              MODE_MIDI: begin
                if (is_on) begin
                  if (count < CW'(MAX_NOTES)) begin
                    count <= count + CW'(1);
                  end
                end else if (is_off) begin
                  rm_note <= note_number;
                  pend_kind <= KIND_OFF;
                  len <= count;
                  pos <= '0;
                  state <= (count == '0) ? ST_EMIT : ST_REMOVE;
                end
              end
              MODE_TICK: begin
                if (beat) begin
                  elapsed <= '0;
                  if (count != '0) begin
                    idx <= step_idx;
                    rep <= step_rep;
                    up <= step_up;
                    pend_kind <= KIND_ON;
                    state <= ST_EMIT;
                  end
                end else begin
                  elapsed <= elapsed_inc;
                end
              end
              MODE_STOP: begin
                pos <= '0;
                if (count != '0) begin
                  state <= ST_STOP;
                end
              end
              default: ;
            endcase
          end
        end
        ST_REMOVE: begin
          len <= len_next;
          pos <= pos + IW'(1);
          if (walk_last) begin
            count <= len_next;
            if (CW'(idx) >= len_next) begin
              idx <= (len_next == '0) ? '0 : IW'(len_next - CW'(1));
            end
            state <= ST_EMIT;
          end
        end
        ST_STOP: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_kind <= KIND_OFF;
            out_note <= head;
            out_velocity <= '0;
            last_of_run <= walk_last;
            pos <= pos + IW'(1);
            if (walk_last) begin
              count <= '0;
              idx <= '0;
              rep <= '0;
              up <= 1'b1;
              state <= ST_IDLE;
            end
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_kind <= pend_kind;
            out_note <= (pend_kind == KIND_OFF) ? rm_note : cells[idx];
            out_velocity <= (pend_kind == KIND_OFF) ? '0 : ON_VELOCITY;
            last_of_run <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/mna_cell.sv -----
// One cell of the held-note chain: holds a note, loads or takes its neighbor's note.
`timescale 1ns / 1ps
module mna_cell
  import mna_pkg::*;
(
  input  logic             clk,
  input  logic             load,
  input  logic             shift,
  input  logic [NoteW-1:0] load_note,
  input  logic [NoteW-1:0] right_note,
  output logic [NoteW-1:0] note
);

  always_ff @(posedge clk) begin
    if (load) begin
      note <= load_note;
    end else if (shift) begin
      note <= right_note;
    end
  end

endmodule

// ----- rtl/mna_step.sv -----
// Pattern stepper: next play index, repeat count and direction for one beat.
`timescale 1ns / 1ps
module mna_step
  import mna_pkg::*;
#(
  parameter int IW = 4,
  parameter int CW = 5
) (
  input  logic [2:0]    pattern,
  input  logic [CW-1:0] count,
  input  logic [IW-1:0] idx,
  input  logic [1:0]    rep,
  input  logic          up,
  output logic [IW-1:0] idx_next,
  output logic [1:0]    rep_next,
  output logic          up_next
);

  logic [CW-1:0] last;
  logic [CW-1:0] idx_w;
  logic [CW-1:0] inc_wrap;
  logic [CW-1:0] sel;
  logic [1:0]    limit;

  always_comb begin
    last = count - CW'(1);
    idx_w = CW'(idx);
    inc_wrap = (idx_w >= last) ? '0 : idx_w + CW'(1);
    limit = (pattern == PAT_REP2) ? 2'd1 : 2'd2;
    sel = idx_w;
    rep_next = rep;
    up_next = up;
    unique case (pattern) inside
      PAT_DOWN: sel = (idx_w == '0) ? last : idx_w - CW'(1);
      PAT_REP2, PAT_REP3: begin
        if (rep < limit) begin
          rep_next = rep + 2'd1;
        end else begin
          rep_next = 2'd0;
          sel = inc_wrap;
        end
      end
      PAT_UPDOWN, PAT_DOWNUP: begin
        if (count < CW'(2)) begin
          sel = '0;
        end else if (up) begin
          if (idx_w < last) begin
            sel = idx_w + CW'(1);
          end else begin
            up_next = 1'b0;
            sel = idx_w - CW'(1);
          end
        end else begin
          if (idx_w > '0) begin
            sel = idx_w - CW'(1);
          end else begin
            up_next = 1'b1;
            sel = idx_w + CW'(1);
          end
        end
      end
      default: sel = inc_wrap;
    endcase
    if (sel >= count) begin
      sel = last;
    end
    idx_next = sel[IW-1:0];
  end

endmodule
